### rtl/tsba_pkg.sv
// Shared constants and width helpers for the tiled surface block address unit.
`timescale 1ns / 1ps

package tsba_pkg;

	// Field widths of the channel words and the configuration port
	localparam int COORD_W    = 11;
	localparam int DATA_W     = 64;
	localparam int OFFSET_W   = 28;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 14;
	localparam int SWZ_W      = 3;
	localparam int MIP_W      = 4;

	// Default largest image side in pixels
	localparam int MAX_DIMENSION_DEF = 8192;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIP_LEVEL    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SWIZZLE      = 2'd3;

	// Macro tile footprint in blocks, micro tile side, element size in bytes
	localparam int MACRO_TILE_W = 32;
	localparam int MACRO_TILE_H = 16;
	localparam int MICRO_TILE   = 8;
	localparam int ELEM_BYTES   = 8;

	// Width of a clamped image side, large enough for its power-of-two ceiling
	function automatic int dim_w(int max_dim);
		return $clog2(max_dim) + 1;
	endfunction

	// Width of aligned pitch and height
	function automatic int al_w(int max_dim);
		return (dim_w(max_dim) > 6) ? dim_w(max_dim) : 6;
	endfunction

	// Width of the surface size in bytes
	function automatic int surf_w(int max_dim);
		return 2 * al_w(max_dim) + 3;
	endfunction

	// Width of the tile row product (row index times tiles per row)
	function automatic int prod_w(int max_dim);
		return 8 + al_w(max_dim) - 3;
	endfunction

	// Width of the linear source block index product
	function automatic int src_w(int max_dim);
		return COORD_W + dim_w(max_dim);
	endfunction

	// Width of the untruncated tiled byte position
	function automatic int pos_w(int max_dim);
		return prod_w(max_dim) + 1 + 12;
	endfunction

	// Width in which the range checks are done
	function automatic int cmp_w(int max_dim);
		int a;
		int b;
		int c;
		int m;
		a = src_w(max_dim) + 4;
		b = pos_w(max_dim) + 1;
		c = surf_w(max_dim);
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

endpackage

### rtl/tsba_if.sv
// Valid/ready channel interfaces for block words and address result words.
`timescale 1ns / 1ps

interface tsba_block_if;
	import tsba_pkg::*;

	logic                valid;
	logic                ready;
	logic [COORD_W-1:0]  block_col;
	logic [COORD_W-1:0]  block_row;
	logic [DATA_W-1:0]   block_data;

	modport source (output valid, output block_col, output block_row, output block_data,
		input ready);
	modport sink (input valid, input block_col, input block_row, input block_data,
		output ready);
endinterface

interface tsba_result_if;
	import tsba_pkg::*;

	logic                valid;
	logic                ready;
	logic [OFFSET_W-1:0] byte_offset;
	logic [DATA_W-1:0]   block_payload;
	logic                fits;
	logic                macro_tiled;

	modport source (output valid, output byte_offset, output block_payload, output fits,
		output macro_tiled, input ready);
	modport sink (input valid, input byte_offset, input block_payload, input fits,
		input macro_tiled, output ready);
endinterface

### rtl/tsba_cfg.sv
// Configuration registers and the surface geometry derived from them.
`timescale 1ns / 1ps

module tsba_cfg #(
	parameter int MAX_DIMENSION = tsba_pkg::MAX_DIMENSION_DEF,
	localparam int DIM_W  = tsba_pkg::dim_w(MAX_DIMENSION),
	localparam int AL_W   = tsba_pkg::al_w(MAX_DIMENSION),
	localparam int SURF_W = tsba_pkg::surf_w(MAX_DIMENSION)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tsba_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tsba_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output logic                            macro_q,
	output logic [AL_W-1:0]                 pitch_q,
	output logic [DIM_W-1:0]                blocks_x_q,
	output logic [SURF_W-1:0]               surf_q,
	output logic [tsba_pkg::SWZ_W-1:0]      swz_q
);
	import tsba_pkg::*;

	logic [CFG_DATA_W-1:0] width_q;
	logic [CFG_DATA_W-1:0] height_raw_q;
	logic [MIP_W-1:0]      mip_q;
	logic [AL_W-1:0]       height_q;

	logic [DIM_W-1:0]      w;
	logic [DIM_W-1:0]      h;
	logic [DIM_W-1:0]      w_p2;
	logic [DIM_W-1:0]      h_p2;
	logic [DIM_W-1:0]      bw;
	logic [DIM_W-1:0]      bh;
	logic                  mip;
	logic                  macro;
	logic [AL_W-1:0]       bw_ext;
	logic [AL_W-1:0]       bh_ext;
	logic [AL_W-1:0]       pitch_d;
	logic [AL_W-1:0]       height_d;
	logic [DIM_W:0]        bx_sum;
	logic [2*AL_W-1:0]     area;

	// Zero reads as one, above the limit saturates
	function automatic logic [DIM_W-1:0] clamp_dim(logic [CFG_DATA_W-1:0] v);
		logic [15:0] ve;
		ve = 16'(v);
		if (ve == 16'd0) begin
			return DIM_W'(1);
		end else if (ve > 16'(MAX_DIMENSION)) begin
			return DIM_W'(MAX_DIMENSION);
		end
		return DIM_W'(ve);
	endfunction

	// Smallest power of two not below v (v is at least one)
	function automatic logic [DIM_W-1:0] pow2_ceil(logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] s;
		s = v - DIM_W'(1);
		for (int i = 1; i < DIM_W; i++) begin
			s = s | (s >> i);
		end
		return s + DIM_W'(1);
	endfunction

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q      <= CFG_DATA_W'(1);
			height_raw_q <= CFG_DATA_W'(1);
			mip_q        <= '0;
			swz_q        <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q      <= cfg_wdata;
				REG_IMAGE_HEIGHT: height_raw_q <= cfg_wdata;
				REG_MIP_LEVEL:    mip_q        <= cfg_wdata[MIP_W-1:0];
				REG_SWIZZLE:      swz_q        <= cfg_wdata[SWZ_W-1:0];
				default: ;
			endcase
		end
	end

	// Block dimensions, tiling mode and alignment
	always_comb begin
		w      = clamp_dim(width_q);
		h      = clamp_dim(height_raw_q);
		mip    = (mip_q != '0);
		w_p2   = pow2_ceil(w);
		h_p2   = pow2_ceil(h);
		bw     = (mip ? w_p2 : w) >> 2;
		bh     = (mip ? h_p2 : h) >> 2;
		if (bw == '0) bw = DIM_W'(1);
		if (bh == '0) bh = DIM_W'(1);
		// on mip levels the block sizes are powers of two already
		macro  = !mip || ((int'(bw) >= MACRO_TILE_W) && (int'(bh) >= MACRO_TILE_H));
		bw_ext = AL_W'(bw);
		bh_ext = AL_W'(bh);
		if (macro) begin
			pitch_d  = (bw_ext + AL_W'(MACRO_TILE_W - 1)) & ~AL_W'(MACRO_TILE_W - 1);
			height_d = (bh_ext + AL_W'(MACRO_TILE_H - 1)) & ~AL_W'(MACRO_TILE_H - 1);
		end else begin
			pitch_d  = (bw_ext + AL_W'(MICRO_TILE - 1)) & ~AL_W'(MICRO_TILE - 1);
			height_d = (bh_ext + AL_W'(MICRO_TILE - 1)) & ~AL_W'(MICRO_TILE - 1);
		end
		bx_sum = (DIM_W + 1)'(w) + (DIM_W + 1)'(3);
	end

	// Geometry registers, refreshed every cycle
	always_ff @(posedge clk) begin
		macro_q    <= macro;
		pitch_q    <= pitch_d;
		height_q   <= height_d;
		blocks_x_q <= DIM_W'(bx_sum >> 2);
		surf_q     <= {area, 3'b000};
	end

	// Surface area in elements, from the registered pitch and height
	assign area = (2 * AL_W)'(height_q) * (2 * AL_W)'(pitch_q);

endmodule

### rtl/tsba_addr_pipe.sv
// Three-stage address pipeline: input register, product register, result register.
`timescale 1ns / 1ps

module tsba_addr_pipe #(
	parameter int MAX_DIMENSION = tsba_pkg::MAX_DIMENSION_DEF,
	localparam int DIM_W  = tsba_pkg::dim_w(MAX_DIMENSION),
	localparam int AL_W   = tsba_pkg::al_w(MAX_DIMENSION),
	localparam int SURF_W = tsba_pkg::surf_w(MAX_DIMENSION)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	tsba_block_if.sink                 blocks,
	tsba_result_if.source              results,
	input  logic                       macro,
	input  logic [AL_W-1:0]            pitch,
	input  logic [DIM_W-1:0]           blocks_x,
	input  logic [SURF_W-1:0]          surf,
	input  logic [tsba_pkg::SWZ_W-1:0] swz
);
	import tsba_pkg::*;

	localparam int PB_W   = AL_W - 3;
	localparam int PROD_W = prod_w(MAX_DIMENSION);
	localparam int SRC_W  = src_w(MAX_DIMENSION);
	localparam int T_W    = PROD_W + 1;
	localparam int POS_W  = pos_w(MAX_DIMENSION);
	localparam int CMP_W  = cmp_w(MAX_DIMENSION);

	// stage valids
	logic v_s1;
	logic v_s2;
	logic v_q;
	logic en_s1;
	logic en_s2;
	logic en_q;

	// stage 1: captured word
	logic [COORD_W-1:0] x_s1;
	logic [COORD_W-1:0] y_s1;
	logic [DATA_W-1:0]  data_s1;

	// stage 2: products
	logic [COORD_W-1:0] x_s2;
	logic [COORD_W-1:0] y_s2;
	logic [DATA_W-1:0]  data_s2;
	logic [PROD_W-1:0]  prod_s2;
	logic [SRC_W-1:0]   src_s2;

	// result register
	logic [OFFSET_W-1:0] offset_q;
	logic [DATA_W-1:0]   data_q;
	logic                fits_q;
	logic                macro_q;

	logic [7:0]         row_idx;
	logic [PB_W-1:0]    row_tiles;
	logic [PROD_W-1:0]  prod_d;
	logic [SRC_W-1:0]   src_d;

	logic [7:0]         col_idx;
	logic [T_W-1:0]     tile;
	logic [5:0]         elem;
	logic [2:0]         bp;
	logic [POS_W-1:0]   pos;
	logic [SRC_W:0]     src_idx;
	logic [CMP_W-1:0]   src_end;
	logic [CMP_W-1:0]   pos_end;
	logic [CMP_W-1:0]   surf_ext;
	logic               fits_d;

	// Handshake: each stage moves when the one after it has room
	assign en_q         = !v_q || results.ready;
	assign en_s2        = !v_s2 || en_q;
	assign en_s1        = !v_s1 || en_s2;
	assign blocks.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_q  <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= blocks.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_q)  v_q  <= v_s2;
		end
	end

	// Tile row times tiles per row, and block row times blocks per row
	always_comb begin
		row_idx   = macro ? {1'b0, y_s1[COORD_W-1:4]} : y_s1[COORD_W-1:3];
		row_tiles = macro ? PB_W'(pitch >> 5) : PB_W'(pitch >> 3);
		prod_d    = PROD_W'(row_idx) * PROD_W'(row_tiles);
		src_d     = SRC_W'(y_s1) * SRC_W'(blocks_x);
	end

	// Tiled position, swizzle and range checks
	always_comb begin
		col_idx  = macro ? {2'b00, x_s2[COORD_W-1:5]} : x_s2[COORD_W-1:3];
		tile     = T_W'(col_idx) + T_W'(prod_s2);
		elem     = {y_s2[2], y_s2[1], x_s2[2], x_s2[1], y_s2[0], x_s2[0]};
		bp       = {y_s2[4] ^ x_s2[4], y_s2[5] ^ x_s2[3], y_s2[3] ^ x_s2[3]} ^ swz;
		if (macro) begin
			pos = {tile, elem[5], bp[2:1], bp[0], elem[4:0], 3'b000};
		end else begin
			pos = POS_W'({tile, elem, 3'b000});
		end
		src_idx  = (SRC_W + 1)'(src_s2) + (SRC_W + 1)'(x_s2);
		src_end  = (CMP_W'(src_idx) + CMP_W'(1)) << 3;
		pos_end  = CMP_W'(pos) + CMP_W'(ELEM_BYTES);
		surf_ext = CMP_W'(surf);
		fits_d   = (src_end <= surf_ext) && (pos_end <= surf_ext);
	end

	// Word registers
	always_ff @(posedge clk) begin
		if (en_s1 && blocks.valid) begin
			x_s1    <= blocks.block_col;
			y_s1    <= blocks.block_row;
			data_s1 <= blocks.block_data;
		end
		if (en_s2 && v_s1) begin
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			data_s2 <= data_s1;
			prod_s2 <= prod_d;
			src_s2  <= src_d;
		end
		if (en_q && v_s2) begin
			offset_q <= OFFSET_W'(pos);
			data_q   <= data_s2;
			fits_q   <= fits_d;
			macro_q  <= macro;
		end
	end

	assign results.valid         = v_q;
	assign results.byte_offset   = offset_q;
	assign results.block_payload = data_q;
	assign results.fits          = fits_q;
	assign results.macro_tiled   = macro_q;

endmodule

### rtl/tiled_surface_block_address.sv
// Top level of the tiled surface block address unit.
`timescale 1ns / 1ps

// Maps 8-byte compressed 4x4 blocks, given by block column and row, to their byte
// offset in a 2D macro-tiled surface (2 pipes, 4 banks, pipe/bank swizzle) with
// 64-bit elements, falling back to 1D micro tiling on small nonzero mip levels.
// Each result word also carries the block data unchanged, a flag that the linear
// source and tiled destination ranges both lie inside the surface, and the mode.
// One block word is taken every clock cycle while back-pressure does not stall the
// pipeline. The input register takes a block at the edge that accepts it, and its
// result word passes the multiply register, then the result register; back-pressure
// stalls the stages in place. Pitch, height and surface size are registered in turn
// from the registers after a write; write them only while no block is in flight.

module tiled_surface_block_address #(
	parameter int MAX_DIMENSION = tsba_pkg::MAX_DIMENSION_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	tsba_block_if.sink                      blocks,
	tsba_result_if.source                   results,
	input  logic                            cfg_we,
	input  logic [tsba_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tsba_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import tsba_pkg::*;

	localparam int DIM_W  = dim_w(MAX_DIMENSION);
	localparam int AL_W   = al_w(MAX_DIMENSION);
	localparam int SURF_W = surf_w(MAX_DIMENSION);

	logic              macro;
	logic [AL_W-1:0]   pitch;
	logic [DIM_W-1:0]  blocks_x;
	logic [SURF_W-1:0] surf;
	logic [SWZ_W-1:0]  swz;

	// Registers and geometry
	tsba_cfg #(
		.MAX_DIMENSION(MAX_DIMENSION)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.macro_q    (macro),
		.pitch_q    (pitch),
		.blocks_x_q (blocks_x),
		.surf_q     (surf),
		.swz_q      (swz)
	);

	// Address pipeline
	tsba_addr_pipe #(
		.MAX_DIMENSION(MAX_DIMENSION)
	) u_pipe (
		.clk      (clk),
		.arst_n   (arst_n),
		.blocks   (blocks),
		.results  (results),
		.macro    (macro),
		.pitch    (pitch),
		.blocks_x (blocks_x),
		.surf     (surf),
		.swz      (swz)
	);

endmodule
